@@ rtl/dcc_pkg.sv @@
// Package: shared types and constants of the drive command controller.
`default_nettype none
package dcc_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned BlinkW = 10;

  localparam logic [SpeedW-1:0] SpeedInitialReset = 8'd128;
  localparam logic [SpeedW-1:0] SpeedMinimumReset = 8'd64;
  localparam logic [SpeedW-1:0] SpeedMaximumReset = 8'd255;
  localparam logic [SpeedW-1:0] SpeedStepReset = 8'd16;
  localparam logic [SpeedW-1:0] TurnSlowReset = 8'd64;
  localparam logic [SpeedW-1:0] TurnFastReset = 8'd192;

  localparam logic [BlinkW-1:0] HalfSlow = 10'd500;
  localparam logic [BlinkW-1:0] HalfQuick = 10'd200;
  localparam logic [BlinkW-1:0] HalfVQuick = 10'd50;

  localparam int unsigned BandDiv = 3;
  localparam int unsigned BandShift = 11;
  localparam int unsigned BandRecip = ((1 << BandShift) + BandDiv - 1) / BandDiv;
  localparam int unsigned BandSumW = SpeedW + 2;
  localparam int unsigned BandProdW = 2 * BandSumW;

  typedef enum logic [3:0] {
    OpStop    = 4'd0,
    OpFwd     = 4'd1,
    OpBack    = 4'd2,
    OpLeft    = 4'd3,
    OpRight   = 4'd4,
    OpAccel   = 4'd5,
    OpDecel   = 4'd6,
    OpTick    = 4'd7,
    OpFwdAt   = 4'd8,
    OpBackAt  = 4'd9
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpeedInitial = 3'd0,
    CfgSpeedMinimum = 3'd1,
    CfgSpeedMaximum = 3'd2,
    CfgSpeedStep    = 3'd3,
    CfgTurnSlow     = 3'd4,
    CfgTurnFast     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MotionStop  = 3'd0,
    MotionFwd   = 3'd1,
    MotionBack  = 3'd2,
    MotionLeft  = 3'd3,
    MotionRight = 3'd4
  } motion_e;

  typedef enum logic [2:0] {
    LampOff    = 3'd0,
    LampOn     = 3'd1,
    LampSlow   = 3'd2,
    LampQuick  = 3'd3,
    LampVQuick = 3'd4
  } lamp_e;

  typedef struct packed {
    logic [SpeedW-1:0] speed_minimum;
    logic [SpeedW-1:0] speed_maximum;
    logic [SpeedW-1:0] speed_step;
    logic [SpeedW-1:0] turn_slow_duty;
    logic [SpeedW-1:0] turn_fast_duty;
    logic [SpeedW-1:0] band_hi;
    logic [SpeedW-1:0] band_lo;
  } cfg_t;

  typedef struct packed {
    logic [SpeedW-1:0] left_duty;
    logic [SpeedW-1:0] right_duty;
    logic              left_reverse;
    logic              right_reverse;
    logic              drive_enable;
    motion_e           motion_mode;
    logic [SpeedW-1:0] current_speed;
    lamp_e             lamp_mode;
    logic              lamp_level;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/dcc_cmd_if.sv @@
// Interface: command request channel.
`default_nettype none
interface dcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [7:0] given_speed;

  modport source (output valid, output operation, output given_speed, input ready);
  modport sink (input valid, input operation, input given_speed, output ready);
endinterface
`default_nettype wire

@@ rtl/dcc_res_if.sv @@
// Interface: result request channel.
`default_nettype none
interface dcc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_duty;
  logic [7:0] right_duty;
  logic       left_reverse;
  logic       right_reverse;
  logic       drive_enable;
  logic [2:0] motion_mode;
  logic [7:0] current_speed;
  logic [2:0] lamp_mode;
  logic       lamp_level;

  modport source (
    output valid, output left_duty, output right_duty, output left_reverse,
    output right_reverse, output drive_enable, output motion_mode,
    output current_speed, output lamp_mode, output lamp_level, input ready
  );
  modport sink (
    input valid, input left_duty, input right_duty, input left_reverse,
    input right_reverse, input drive_enable, input motion_mode,
    input current_speed, input lamp_mode, input lamp_level, output ready
  );
endinterface
`default_nettype wire

@@ rtl/drive_command_controller.sv @@
// Top level: drive command controller for a two-motor car.
//
// Each command or millisecond tick is taken into an input register and its result, the full
// drive and lamp state after the update, is registered in the output register once that is free.
// One request is accepted every cycle while results are taken; a result that waits holds the
// next request in the input register and stalls further requests until it is taken. The
// figure is set by the combinational state update between the input and the output register.
// Register writes take effect at once. Velocity loads 128 at reset; index 0 is taken but has
// no effect afterwards, and indexes above 5 are ignored.
`default_nettype none
module drive_command_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dcc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dcc_pkg::SpeedW-1:0]  cfg_data_i,
  dcc_cmd_if.sink                          cmd_i,
  dcc_res_if.source                        res_o
);
  import dcc_pkg::*;

  cfg_t              cfg;
  res_t              state_d, out_q;
  logic              in_valid_q, out_valid_q, advance;
  logic [3:0]        op_q;
  logic [SpeedW-1:0] given_q;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      op_q    <= cmd_i.operation;
      given_q <= cmd_i.given_speed;
    end
    if (advance) begin
      out_q <= state_d;
    end
  end

  dcc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dcc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .op_i      (op_q),
    .given_i   (given_q),
    .cfg_i     (cfg),
    .state_d_o (state_d)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.left_duty     = out_q.left_duty;
  assign res_o.right_duty    = out_q.right_duty;
  assign res_o.left_reverse  = out_q.left_reverse;
  assign res_o.right_reverse = out_q.right_reverse;
  assign res_o.drive_enable  = out_q.drive_enable;
  assign res_o.motion_mode   = out_q.motion_mode;
  assign res_o.current_speed = out_q.current_speed;
  assign res_o.lamp_mode     = out_q.lamp_mode;
  assign res_o.lamp_level    = out_q.lamp_level;
endmodule
`default_nettype wire

@@ rtl/dcc_cfg.sv @@
// Configuration registers and lamp band thresholds.
`default_nettype none
module dcc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dcc_pkg::SpeedW-1:0]   cfg_data_i,
  output dcc_pkg::cfg_t                     cfg_o
);
  import dcc_pkg::*;

  logic [SpeedW-1:0]    min_q, max_q, step_q, slow_q, fast_q;
  logic [BandSumW-1:0]  sum_hi, sum_lo;
  logic [BandProdW-1:0] prod_hi, prod_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= SpeedMinimumReset;
      max_q  <= SpeedMaximumReset;
      step_q <= SpeedStepReset;
      slow_q <= TurnSlowReset;
      fast_q <= TurnFastReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSpeedMinimum: min_q  <= cfg_data_i;
        CfgSpeedMaximum: max_q  <= cfg_data_i;
        CfgSpeedStep:    step_q <= cfg_data_i;
        CfgTurnSlow:     slow_q <= cfg_data_i;
        CfgTurnFast:     fast_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divide by three through a reciprocal, exact for sums below 1024
  assign sum_hi  = {1'b0, max_q, 1'b0} + {2'b00, min_q};
  assign sum_lo  = {2'b00, max_q} + {1'b0, min_q, 1'b0};
  assign prod_hi = {{BandSumW{1'b0}}, sum_hi} * BandProdW'(BandRecip);
  assign prod_lo = {{BandSumW{1'b0}}, sum_lo} * BandProdW'(BandRecip);

  always_comb begin
    cfg_o.speed_minimum  = min_q;
    cfg_o.speed_maximum  = max_q;
    cfg_o.speed_step     = step_q;
    cfg_o.turn_slow_duty = slow_q;
    cfg_o.turn_fast_duty = fast_q;
    cfg_o.band_hi        = prod_hi[BandShift+SpeedW-1:BandShift];
    cfg_o.band_lo        = prod_lo[BandShift+SpeedW-1:BandShift];
  end
endmodule
`default_nettype wire

@@ rtl/dcc_core.sv @@
// Drive state registers and their single-pass update.
`default_nettype none
module dcc_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire logic [3:0]                  op_i,
  input  wire logic [dcc_pkg::SpeedW-1:0]  given_i,
  input  wire dcc_pkg::cfg_t               cfg_i,
  output dcc_pkg::res_t                    state_d_o
);
  import dcc_pkg::*;

  res_t              st_q, st_d;
  logic [BlinkW-1:0] elapsed_q, elapsed_d, elapsed_inc, half;
  logic [SpeedW:0]   sum, diff;
  logic              sel_en, sel_off, blinking;
  lamp_e             band, tgt;

  assign sum  = {1'b0, st_q.current_speed} + {1'b0, cfg_i.speed_step};
  assign diff = {1'b0, st_q.current_speed} - {1'b0, cfg_i.speed_step};
  assign elapsed_inc = elapsed_q + BlinkW'(1);

  always_comb begin
    st_d      = st_q;
    elapsed_d = elapsed_q;
    sel_en    = 1'b0;
    sel_off   = 1'b0;
    blinking  = 1'b0;
    half      = HalfSlow;
    case (op_e'(op_i))
      OpStop: begin
        st_d.motion_mode  = MotionStop;
        st_d.drive_enable = 1'b0;
        sel_en  = 1'b1;
        sel_off = 1'b1;
      end
      OpFwd, OpBack, OpFwdAt, OpBackAt: begin
        st_d.motion_mode   = (op_e'(op_i) == OpFwd || op_e'(op_i) == OpFwdAt) ?
                             MotionFwd : MotionBack;
        st_d.left_reverse  = (op_e'(op_i) == OpBack || op_e'(op_i) == OpBackAt);
        st_d.right_reverse = (op_e'(op_i) == OpBack || op_e'(op_i) == OpBackAt);
        st_d.left_duty     = (op_e'(op_i) == OpFwd || op_e'(op_i) == OpBack) ?
                             st_q.current_speed : given_i;
        st_d.right_duty    = st_d.left_duty;
        st_d.drive_enable  = 1'b1;
        sel_en = (op_e'(op_i) == OpFwd || op_e'(op_i) == OpBack);
      end
      OpLeft, OpRight: begin
        st_d.motion_mode   = (op_e'(op_i) == OpLeft) ? MotionLeft : MotionRight;
        st_d.left_reverse  = 1'b0;
        st_d.right_reverse = 1'b0;
        st_d.left_duty     = (op_e'(op_i) == OpLeft) ? cfg_i.turn_slow_duty
                                                     : cfg_i.turn_fast_duty;
        st_d.right_duty    = (op_e'(op_i) == OpLeft) ? cfg_i.turn_fast_duty
                                                     : cfg_i.turn_slow_duty;
        st_d.drive_enable  = 1'b1;
      end
      OpAccel, OpDecel: begin
        if (op_e'(op_i) == OpAccel) begin
          st_d.current_speed = (sum > {1'b0, cfg_i.speed_maximum}) ?
                               cfg_i.speed_maximum : sum[SpeedW-1:0];
        end else begin
          st_d.current_speed = (diff[SpeedW] || diff[SpeedW-1:0] < cfg_i.speed_minimum) ?
                               cfg_i.speed_minimum : diff[SpeedW-1:0];
        end
        if (st_q.motion_mode == MotionFwd || st_q.motion_mode == MotionBack) begin
          st_d.left_duty  = st_d.current_speed;
          st_d.right_duty = st_d.current_speed;
        end
        sel_en = 1'b1;
      end
      OpTick: begin
        case (st_q.lamp_mode)
          LampSlow:   begin half = HalfSlow;   blinking = 1'b1; end
          LampQuick:  begin half = HalfQuick;  blinking = 1'b1; end
          LampVQuick: begin half = HalfVQuick; blinking = 1'b1; end
          default: ;
        endcase
        if (blinking) begin
          if (elapsed_inc > half) begin
            elapsed_d       = '0;
            st_d.lamp_level = ~st_q.lamp_level;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end
      default: ;
    endcase

    if (st_d.current_speed == cfg_i.speed_maximum) begin
      band = LampOn;
    end else if (st_d.current_speed > cfg_i.band_hi) begin
      band = LampVQuick;
    end else if (st_d.current_speed > cfg_i.band_lo) begin
      band = LampQuick;
    end else if (st_d.current_speed == cfg_i.speed_minimum) begin
      band = LampOn;
    end else begin
      band = LampSlow;
    end
    tgt = sel_off ? LampOff : band;

    if (sel_en && tgt != st_q.lamp_mode) begin
      st_d.lamp_mode  = tgt;
      st_d.lamp_level = (tgt != LampOff);
      if (tgt != LampOff && tgt != LampOn) begin
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.left_duty     <= '0;
      st_q.right_duty    <= '0;
      st_q.left_reverse  <= 1'b0;
      st_q.right_reverse <= 1'b0;
      st_q.drive_enable  <= 1'b0;
      st_q.motion_mode   <= MotionStop;
      st_q.current_speed <= SpeedInitialReset;
      st_q.lamp_mode     <= LampOff;
      st_q.lamp_level    <= 1'b0;
      elapsed_q          <= '0;
    end else if (advance_i) begin
      st_q      <= st_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign state_d_o = st_d;
endmodule
`default_nettype wire

@@ rtl/dcc_checker.sv @@
// Checker on the top-level ports of the drive command controller, with its bind.
`default_nettype none
module dcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       left_reverse,
  input wire logic       right_reverse,
  input wire logic       drive_enable,
  input wire logic [2:0] motion_mode,
  input wire logic [2:0] lamp_mode,
  input wire logic       lamp_level
);
  import dcc_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  a_enable_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (drive_enable == (motion_mode != MotionStop)))
    else $error("drive enable disagrees with motion mode");

  a_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (left_reverse == right_reverse) &&
                  (motion_mode == MotionStop ||
                   left_reverse == (motion_mode == MotionBack)))
    else $error("direction bits disagree with motion mode");

  a_lamp_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (lamp_mode == LampOff || lamp_mode == LampOn) |->
      (lamp_level == (lamp_mode == LampOn)))
    else $error("lamp level wrong for steady lamp mode");
endmodule

bind drive_command_controller dcc_checker u_dcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .left_reverse  (res_o.left_reverse),
  .right_reverse (res_o.right_reverse),
  .drive_enable  (res_o.drive_enable),
  .motion_mode   (res_o.motion_mode),
  .lamp_mode     (res_o.lamp_mode),
  .lamp_level    (res_o.lamp_level)
);
`default_nettype wire

@@ test/tb_drive_command_controller.sv @@
// Testbench of the drive command controller: random and directed requests against a predictor.
`timescale 1ns / 1ps
module tb_drive_command_controller;
  import dcc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RegCount = 6;
  localparam int unsigned IdxSlots = 1 << CfgIdxW;
  localparam logic [3:0] OpFirstUnused = 4'd10;
  localparam logic [3:0] OpLastUnused = 4'd15;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [SpeedW-1:0] cfg_data;

  dcc_cmd_if cmd_ch ();
  dcc_res_if res_ch ();

  drive_command_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_ch),
    .res_o      (res_ch)
  );

  logic [7:0] cfg_min, cfg_max, cfg_step, cfg_slow, cfg_fast;
  logic [7:0] speed_now, duty_l, duty_r;
  logic rev_l, rev_r, pwm_en, lamp_lvl;
  motion_e motion_now;
  lamp_e lamp_now;
  logic [BlinkW-1:0] blink_cnt;

  res_t pending_states[$];
  int fail_count = 0;
  int unsigned cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb_drive_command_controller NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic select_lamp(input lamp_e m);
    if (m != lamp_now) begin
      lamp_now = m;
      lamp_lvl = (m != LampOff);
      if (m != LampOff && m != LampOn) blink_cnt = '0;
    end
  endtask

  task automatic lamp_for_speed();
    int hi, lo;
    hi = (2 * int'(cfg_max) + int'(cfg_min)) / BandDiv;
    lo = (int'(cfg_max) + 2 * int'(cfg_min)) / BandDiv;
    if (speed_now == cfg_max) select_lamp(LampOn);
    else if (int'(speed_now) > hi) select_lamp(LampVQuick);
    else if (int'(speed_now) > lo) select_lamp(LampQuick);
    else if (speed_now == cfg_min) select_lamp(LampOn);
    else select_lamp(LampSlow);
  endtask

  task automatic drive_straight(input motion_e m, input logic [7:0] duty, input logic rev);
    motion_now = m;
    rev_l = rev;
    rev_r = rev;
    duty_l = duty;
    duty_r = duty;
    pwm_en = 1'b1;
  endtask

  task automatic drive_turn(input motion_e m, input logic [7:0] dl, input logic [7:0] dr);
    motion_now = m;
    rev_l = 1'b0;
    rev_r = 1'b0;
    duty_l = dl;
    duty_r = dr;
    pwm_en = 1'b1;
  endtask

  task automatic speed_to_duties();
    if (motion_now == MotionFwd || motion_now == MotionBack) begin
      duty_l = speed_now;
      duty_r = speed_now;
    end
  endtask

  task automatic predict_drive(input logic [3:0] op, input logic [7:0] given);
    logic [8:0] total;
    logic [BlinkW-1:0] half;
    res_t r;
    case (op)
      OpStop: begin
        motion_now = MotionStop;
        pwm_en = 1'b0;
        select_lamp(LampOff);
      end
      OpFwd: begin
        drive_straight(MotionFwd, speed_now, 1'b0);
        lamp_for_speed();
      end
      OpBack: begin
        drive_straight(MotionBack, speed_now, 1'b1);
        lamp_for_speed();
      end
      OpLeft: drive_turn(MotionLeft, cfg_slow, cfg_fast);
      OpRight: drive_turn(MotionRight, cfg_fast, cfg_slow);
      OpAccel: begin
        total = speed_now + cfg_step;
        speed_now = (total > cfg_max) ? cfg_max : total[7:0];
        lamp_for_speed();
        speed_to_duties();
      end
      OpDecel: begin
        if (speed_now < cfg_step || speed_now - cfg_step < cfg_min) speed_now = cfg_min;
        else speed_now = speed_now - cfg_step;
        lamp_for_speed();
        speed_to_duties();
      end
      OpTick: begin
        half = '0;
        case (lamp_now)
          LampSlow: half = HalfSlow;
          LampQuick: half = HalfQuick;
          LampVQuick: half = HalfVQuick;
          default: ;
        endcase
        if (half != '0) begin
          blink_cnt = blink_cnt + 1'b1;
          if (blink_cnt > half) begin
            blink_cnt = '0;
            lamp_lvl = ~lamp_lvl;
          end
        end
      end
      OpFwdAt: drive_straight(MotionFwd, given, 1'b0);
      OpBackAt: drive_straight(MotionBack, given, 1'b1);
      default: ;
    endcase
    r.left_duty = duty_l;
    r.right_duty = duty_r;
    r.left_reverse = rev_l;
    r.right_reverse = rev_r;
    r.drive_enable = pwm_en;
    r.motion_mode = motion_now;
    r.current_speed = speed_now;
    r.lamp_mode = lamp_now;
    r.lamp_level = lamp_lvl;
    pending_states.push_back(r);
  endtask

  task automatic compare_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_states.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        fail_count++;
      end else begin
        want = pending_states.pop_front();
        compare_field("left_duty", want.left_duty, res_ch.left_duty);
        compare_field("right_duty", want.right_duty, res_ch.right_duty);
        compare_field("left_reverse", want.left_reverse, res_ch.left_reverse);
        compare_field("right_reverse", want.right_reverse, res_ch.right_reverse);
        compare_field("drive_enable", want.drive_enable, res_ch.drive_enable);
        compare_field("motion_mode", want.motion_mode, res_ch.motion_mode);
        compare_field("current_speed", want.current_speed, res_ch.current_speed);
        compare_field("lamp_mode", want.lamp_mode, res_ch.lamp_mode);
        compare_field("lamp_level", want.lamp_level, res_ch.lamp_level);
      end
    end
  end

  task automatic send_cmd(input logic [3:0] op, input logic [7:0] given);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.given_speed <= given;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    predict_drive(op, given);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending_states.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] vals[RegCount], input bit with_unused);
    int slots;
    logic [7:0] value;
    slots = with_unused ? IdxSlots : RegCount;
    drain_results();
    for (int i = 0; i < slots; i++) begin
      value = (i < RegCount) ? vals[i] : 8'($urandom);
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= value;
      @(posedge clk_i);
      case (cfg_idx_e'(i))
        CfgSpeedMinimum: cfg_min = value;
        CfgSpeedMaximum: cfg_max = value;
        CfgSpeedStep: cfg_step = value;
        CfgTurnSlow: cfg_slow = value;
        CfgTurnFast: cfg_fast = value;
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) send_cmd(OpAccel, 8'($urandom));
    else if (pick < 40) send_cmd(OpDecel, 8'($urandom));
    else if (pick < 48) send_cmd(OpFwd, 8'($urandom));
    else if (pick < 56) send_cmd(OpBack, 8'($urandom));
    else if (pick < 61) send_cmd(OpFwdAt, 8'($urandom));
    else if (pick < 66) send_cmd(OpBackAt, 8'($urandom));
    else if (pick < 71) send_cmd(OpLeft, 8'($urandom));
    else if (pick < 76) send_cmd(OpRight, 8'($urandom));
    else if (pick < 80) send_cmd(OpStop, 8'($urandom));
    else if (pick < 84) send_cmd(4'($urandom_range(OpFirstUnused, OpLastUnused)),
                                 8'($urandom));
    else if (pick < 98) repeat ($urandom_range(1, 12)) send_cmd(OpTick, 8'($urandom));
    else drain_results();
  endtask

  task automatic test_reset_outputs();
    send_cmd(OpLastUnused, 8'hFF);
  endtask

  task automatic test_each_operation();
    send_cmd(OpFwd, 8'h00);
    send_cmd(OpAccel, 8'h00);
    send_cmd(OpDecel, 8'h00);
    send_cmd(OpBack, 8'h00);
    send_cmd(OpAccel, 8'h00);
    send_cmd(OpLeft, 8'h00);
    send_cmd(OpRight, 8'h00);
    send_cmd(OpTick, 8'h00);
    send_cmd(OpFwdAt, 8'hFF);
    send_cmd(OpBackAt, 8'h00);
    send_cmd(OpStop, 8'h00);
    send_cmd(OpDecel, 8'hA5);
    send_cmd(OpFirstUnused, 8'h5A);
  endtask

  task automatic test_saturation();
    logic [7:0] regs[RegCount];
    regs = '{8'd128, 8'd64, 8'd255, 8'd255, 8'd64, 8'd192};
    write_regs(regs, 1'b1);
    send_cmd(OpFwd, 8'h00);
    send_cmd(OpAccel, 8'h00);
    send_cmd(OpDecel, 8'h00);
    regs = '{8'd0, 8'd200, 8'd100, 8'd1, 8'd0, 8'd255};
    write_regs(regs, 1'b0);
    send_cmd(OpAccel, 8'h00);
    send_cmd(OpDecel, 8'h00);
    send_cmd(OpLeft, 8'h00);
  endtask

  task automatic test_register_settings();
    logic [7:0] regs[RegCount];
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: regs = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255};
        1: regs = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0};
        2: regs = '{8'd17, 8'd0, 8'd0, 8'd255, 8'd128, 8'd1};
        3: regs = '{8'd99, 8'd250, 8'd3, 8'd7, 8'd33, 8'd66};
        default: regs = '{SpeedInitialReset, SpeedMinimumReset, SpeedMaximumReset,
                          SpeedStepReset, TurnSlowReset, TurnFastReset};
      endcase
      write_regs(regs, s == 0);
      repeat (20) send_random_cmd();
    end
  endtask

  task automatic test_lamp_blink();
    logic [7:0] regs[RegCount];
    regs = '{SpeedInitialReset, SpeedMinimumReset, SpeedMaximumReset,
             SpeedStepReset, TurnSlowReset, TurnFastReset};
    write_regs(regs, 1'b0);
    send_cmd(OpStop, 8'h00);
    while (speed_now != cfg_min) send_cmd(OpDecel, 8'($urandom));
    send_cmd(OpFwd, 8'($urandom));
    send_cmd(OpAccel, 8'($urandom));
    repeat (int'(HalfSlow) + 2 + $urandom_range(0, 10)) send_cmd(OpTick, 8'($urandom));
    repeat (4) send_cmd(OpAccel, 8'($urandom));
    repeat (int'(HalfQuick) + 2 + $urandom_range(0, 10)) send_cmd(OpTick, 8'($urandom));
    repeat (4) send_cmd(OpAccel, 8'($urandom));
    repeat (2 * int'(HalfVQuick) + 4 + $urandom_range(0, 10))
      send_cmd(OpTick, 8'($urandom));
  endtask

  task automatic test_random_traffic();
    logic [7:0] regs[RegCount];
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 52; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 52; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      regs = '{8'($urandom), 8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)),
               8'($urandom_range(1, 64)), 8'($urandom), 8'($urandom)};
      write_regs(regs, 1'b1);
      repeat (90) send_random_cmd();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.operation <= '0;
    cmd_ch.given_speed <= '0;
    cfg_min = SpeedMinimumReset;
    cfg_max = SpeedMaximumReset;
    cfg_step = SpeedStepReset;
    cfg_slow = TurnSlowReset;
    cfg_fast = TurnFastReset;
    speed_now = SpeedInitialReset;
    motion_now = MotionStop;
    lamp_now = LampOff;
    lamp_lvl = 1'b0;
    blink_cnt = '0;
    duty_l = '0;
    duty_r = '0;
    rev_l = 1'b0;
    rev_r = 1'b0;
    pwm_en = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_outputs();
    test_each_operation();
    test_saturation();
    test_register_settings();
    send_idle_pct = 7;
    stall_pct = 7;
    test_lamp_blink();
    test_random_traffic();

    drain_results();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && pending_states.size() == 0) begin
      $display("tb_drive_command_controller OK");
    end else begin
      $display("tb_drive_command_controller NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dcc_pkg.sv
rtl/dcc_cmd_if.sv
rtl/dcc_res_if.sv
rtl/dcc_cfg.sv
rtl/dcc_core.sv
rtl/drive_command_controller.sv
rtl/dcc_checker.sv
test/tb_drive_command_controller.sv
